[hdl/householder_plane_reflect_macros.svh]
// ----------------------------------------------------------------------------
// householder plane reflect assertion macros
// concurrent checks clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef HOUSEHOLDER_PLANE_REFLECT_MACROS_SVH
`define HOUSEHOLDER_PLANE_REFLECT_MACROS_SVH

// same-cycle implication
`define HPR_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HPR_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/hpr_pkg.sv]
// ----------------------------------------------------------------------------
// hpr_pkg
// shared types and constants of the householder plane reflect block
// ----------------------------------------------------------------------------
package hpr_pkg;

	localparam int FRAC_BITS_DEF = 30;
	localparam int FRAC_MIN      = 16;
	// cross product magnitude width, sized for the smallest fraction width
	localparam int CMAG_W        = 65 - FRAC_MIN;
	localparam int SHIFT_W       = $clog2(CMAG_W - 31 + 1);
	localparam int QDEPTH_DEF    = 4;
	localparam logic [31:0] MIN_CROSS_RESET = 32'd1;

	typedef struct packed {
		logic signed [31:0] look_x;
		logic signed [31:0] look_y;
		logic signed [31:0] look_z;
		logic signed [31:0] obs_x;
		logic signed [31:0] obs_y;
		logic signed [31:0] obs_z;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] refl_x;
		logic signed [31:0] refl_y;
		logic signed [31:0] refl_z;
		logic               normal_raw;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [2:0][31:0]        vec;
		logic [2:0]              neg;
		logic [2:0][31:0]        uraw;
		logic [2:0][CMAG_W-1:0]  mag;
		logic [SHIFT_W-1:0]      shift;
		logic                    norm;
	} qent_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} qstat_t;

endpackage

[hdl/householder_plane_reflect.sv]
// ----------------------------------------------------------------------------
// householder_plane_reflect
// reflects a vector across the plane normal to look x observer
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one geometry transaction per unstalled
//   cycle: look direction, observer position and vector to reflect. out_valid/
//   out_stall/out_data return one reflected vector per transaction, in order,
//   with normal_raw set when the cross product was at or below the threshold.
//   cfg_we/cfg_wdata set min_cross_magnitude; write it only while idle.
// Throughput: one transaction per cycle when neither side stalls.
// Pipeline: the back holds the 32-stage square root and the FRAC_BITS+1
//   stage divider.
// Reset: arst_n clears all valid bits and the queue, and loads the threshold
//   with one.
// Stall: out_stall with out_valid high freezes the back pipeline; the front
//   keeps accepting until the queue between them fills, then raises in_stall.
// ----------------------------------------------------------------------------
`include "householder_plane_reflect_macros.svh"

module householder_plane_reflect import hpr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int QDEPTH    = QDEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	logic [31:0] min_cross_q;
	logic        push;
	qent_t       push_data;
	qent_t       head_data;
	logic        pop;
	qstat_t      q_stat;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_cross_q <= MIN_CROSS_RESET;
		else if (cfg_we) min_cross_q <= cfg_wdata;
	end

	// classification front
	hpr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.min_cross (min_cross_q),
		.q_full    (q_stat.full),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	hpr_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (head_data),
		.stat   (q_stat)
	);

	// normalize and reflect back
	hpr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_stat.empty),
		.q_rdata   (head_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// checks
	`HPR_ASSERT_NOW(a_stall_needs_full, in_stall, q_stat.full, "input stalled with room in queue")
	`HPR_ASSERT_NOW(a_push_not_full, q_stat.push, !q_stat.full, "push into a full queue")
	`HPR_ASSERT_NOW(a_pop_not_empty, q_stat.pop, !q_stat.empty, "pop from an empty queue")
	`HPR_ASSERT_NEXT(a_full_stays_busy, q_stat.full, !q_stat.empty, "full queue drained at once")

endmodule

[hdl/hpr_front.sv]
// ----------------------------------------------------------------------------
// hpr_front
// accepts items, forms the cross product and decides on normalization
// ----------------------------------------------------------------------------
module hpr_front import hpr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	input  logic [31:0] min_cross,
	input  logic        q_full,
	output logic        push,
	output qent_t       push_data
);

	localparam int PW = $clog2(CMAG_W);
	localparam logic signed [CMAG_W-1:0] ONE_C = {{(CMAG_W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [31:0] ONE_W = 32'd1 << FRAC_BITS;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [63:0]        prod_s1 [6];
	logic [2:0][31:0]          vec_s1, vec_s2, vec_s3, vec_s4;
	logic signed [CMAG_W-1:0]  cross_s2 [3];
	logic [2:0][CMAG_W-1:0]    mag_s3, mag_s4;
	logic [2:0]                neg_s3, neg_s4;
	logic [2:0][31:0]          uraw_s3, uraw_s4;
	logic                      big_s3, big_s4;
	logic [63:0]               sq_s4 [3];
	logic [63:0]               t2_s4;
	logic [CMAG_W-1:0]         mx_s4;
	qent_t                     ent_s5;

	logic signed [64:0]        diff [3];
	logic signed [64:0]        diff_sh [3];
	logic [65:0]               sqsum;
	logic [PW-1:0]             pos;
	logic [CMAG_W-1:0]         mx01;

	// stall the whole front when its last item cannot enter the queue
	assign en       = !(v_s5 && q_full);
	assign in_stall = !en;
	assign push     = v_s5 && !q_full;
	assign push_data = ent_s5;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// cross product differences, exact before the floor shift
	always_comb begin
		diff[0] = {prod_s1[0][63], prod_s1[0]} - {prod_s1[1][63], prod_s1[1]};
		diff[1] = {prod_s1[2][63], prod_s1[2]} - {prod_s1[3][63], prod_s1[3]};
		diff[2] = {prod_s1[4][63], prod_s1[4]} - {prod_s1[5][63], prod_s1[5]};
		for (int i = 0; i < 3; i++) begin
			diff_sh[i] = diff[i] >>> FRAC_BITS;
		end
	end

	// sum of squares and leading one of the largest magnitude
	always_comb begin
		sqsum = {2'b00, sq_s4[0]} + {2'b00, sq_s4[1]} + {2'b00, sq_s4[2]};
		pos = '0;
		for (int i = 0; i < CMAG_W; i++) begin
			if (mx_s4[i]) pos = PW'(i);
		end
		mx01 = (mag_s3[1] > mag_s3[0]) ? mag_s3[1] : mag_s3[0];
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// products of look and observer components
			prod_s1[0] <= $signed(in_data.look_y) * $signed(in_data.obs_z);
			prod_s1[1] <= $signed(in_data.look_z) * $signed(in_data.obs_y);
			prod_s1[2] <= $signed(in_data.look_z) * $signed(in_data.obs_x);
			prod_s1[3] <= $signed(in_data.look_x) * $signed(in_data.obs_z);
			prod_s1[4] <= $signed(in_data.look_x) * $signed(in_data.obs_y);
			prod_s1[5] <= $signed(in_data.look_y) * $signed(in_data.obs_x);
			vec_s1 <= {in_data.vec_z, in_data.vec_y, in_data.vec_x};

			// cross components
			for (int i = 0; i < 3; i++) begin
				cross_s2[i] <= diff_sh[i][CMAG_W-1:0];
			end
			vec_s2 <= vec_s1;

			// magnitudes, signs and the clamped raw normal
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= cross_s2[i][CMAG_W-1];
				mag_s3[i] <= cross_s2[i][CMAG_W-1] ? -cross_s2[i] : cross_s2[i];
				if (cross_s2[i] > ONE_C) begin
					uraw_s3[i] <= ONE_W;
				end else if (cross_s2[i] < -ONE_C) begin
					uraw_s3[i] <= -ONE_W;
				end else begin
					uraw_s3[i] <= cross_s2[i][31:0];
				end
			end
			big_s3 <= (|(-cross_s2[0]) & cross_s2[0][CMAG_W-1] ?
				|((-cross_s2[0]) >> 32) : |(cross_s2[0] >> 32)) ||
				(cross_s2[1][CMAG_W-1] ? |((-cross_s2[1]) >> 32) : |(cross_s2[1] >> 32)) ||
				(cross_s2[2][CMAG_W-1] ? |((-cross_s2[2]) >> 32) : |(cross_s2[2] >> 32));
			vec_s3 <= vec_s2;

			// squares, threshold square and largest magnitude
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= mag_s3[i][31:0] * mag_s3[i][31:0];
			end
			t2_s4  <= min_cross * min_cross;
			mx_s4  <= (mag_s3[2] > mx01) ? mag_s3[2] : mx01;
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			uraw_s4 <= uraw_s3;
			big_s4 <= big_s3;
			vec_s4 <= vec_s3;

			// classify and pick the shift that brings the magnitudes under 2^31
			ent_s5.norm  <= big_s4 || (sqsum > {2'b00, t2_s4});
			ent_s5.shift <= (pos >= PW'(31)) ? SHIFT_W'(pos - PW'(30)) : '0;
			ent_s5.mag   <= mag_s4;
			ent_s5.neg   <= neg_s4;
			ent_s5.uraw  <= uraw_s4;
			ent_s5.vec   <= vec_s4;
		end
	end

endmodule

[hdl/hpr_queue.sv]
// ----------------------------------------------------------------------------
// hpr_queue
// short first-in first-out buffer between the front and the back
// ----------------------------------------------------------------------------
module hpr_queue import hpr_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qent_t  wdata,
	input  logic   pop,
	output qent_t  rdata,
	output qstat_t stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qent_t          mem_q [DEPTH];
	logic [AW-1:0]  wptr_q, rptr_q;
	logic [CW-1:0]  count_q;

	assign rdata      = mem_q[rptr_q];
	assign stat.push  = push;
	assign stat.pop   = pop;
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)  rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

endmodule

[hdl/hpr_back.sv]
// ----------------------------------------------------------------------------
// hpr_back
// normalizes a flagged normal by pipelined root and divide, then reflects
// ----------------------------------------------------------------------------
module hpr_back import hpr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  qent_t     q_rdata,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int RW = 32;          // root bits
	localparam int SW = 66;          // root remainder width
	localparam int QW = FRAC_BITS + 1;
	localparam int DW = 34;          // dot product after shift

	typedef struct packed {
		logic [2:0][31:0] vec;
		logic [2:0]       neg;
		logic [2:0][31:0] uraw;
		logic             norm;
		logic [2:0][30:0] bval;
	} ctx_t;

	logic en;

	// head stages
	logic             hd_v_s1, hd_v_s2, hd_v_s3;
	ctx_t             hd_ctx_s1, hd_ctx_s2, hd_ctx_s3;
	logic [61:0]      hd_bsq_s2 [3];
	logic [63:0]      hd_sum_s3;

	// root stages
	logic             sr_v    [RW+1];
	logic [SW-1:0]    sr_rem  [RW+1];
	logic [RW-1:0]    sr_root [RW+1];
	ctx_t             sr_ctx  [RW+1];

	// divide stages
	logic             dv_v   [QW+1];
	logic [32:0]      dv_rem [QW+1][3];
	logic [QW-1:0]    dv_q   [QW+1][3];
	logic [31:0]      dv_m   [QW+1];
	ctx_t             dv_ctx [QW+1];

	// tail stages
	logic                tl_v_s1, tl_v_s2, tl_v_s3, tl_v_s4;
	logic signed [31:0]  tl_u_s1 [3];
	logic signed [31:0]  tl_u_s2 [3];
	logic signed [31:0]  tl_u_s3 [3];
	logic [2:0][31:0]    tl_vec_s1, tl_vec_s2, tl_vec_s3, tl_vec_s4;
	logic                tl_norm_s1, tl_norm_s2, tl_norm_s3, tl_norm_s4;
	logic signed [63:0]  tl_prod_s2 [3];
	logic signed [DW-1:0] tl_dot_s3;
	logic signed [65:0]  tl_scl_s4 [3];

	logic signed [65:0]  dsum;
	logic signed [65:0]  dsum_sh;
	logic signed [65:0]  scl_sh [3];
	logic signed [35:0]  rdiff [3];
	logic [31:0]         rsat [3];

	// one enable for the whole back, held while the result waits
	assign en  = !(out_valid && out_stall);
	assign pop = en && !q_empty;

	// head valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_v_s1 <= 1'b0;
			hd_v_s2 <= 1'b0;
			hd_v_s3 <= 1'b0;
		end else if (en) begin
			hd_v_s1 <= !q_empty;
			hd_v_s2 <= hd_v_s1;
			hd_v_s3 <= hd_v_s2;
		end
	end

	// scaled magnitudes, their squares and the sum under the root
	always_ff @(posedge clk) begin
		if (en) begin
			hd_ctx_s1.vec  <= q_rdata.vec;
			hd_ctx_s1.neg  <= q_rdata.neg;
			hd_ctx_s1.uraw <= q_rdata.uraw;
			hd_ctx_s1.norm <= q_rdata.norm;
			for (int i = 0; i < 3; i++) begin
				hd_ctx_s1.bval[i] <= 31'(q_rdata.mag[i] >> q_rdata.shift);
			end
			for (int i = 0; i < 3; i++) begin
				hd_bsq_s2[i] <= hd_ctx_s1.bval[i] * hd_ctx_s1.bval[i];
			end
			hd_ctx_s2 <= hd_ctx_s1;
			hd_sum_s3 <= {2'b00, hd_bsq_s2[0]} + {2'b00, hd_bsq_s2[1]} +
				{2'b00, hd_bsq_s2[2]};
			hd_ctx_s3 <= hd_ctx_s2;
		end
	end

	// root pipeline input
	always_comb begin
		sr_v[0]    = hd_v_s3;
		sr_rem[0]  = {2'b00, hd_sum_s3};
		sr_root[0] = '0;
		sr_ctx[0]  = hd_ctx_s3;
	end

	// integer square root, one result bit per stage
	for (genvar g = 0; g < RW; g++) begin : g_root
		localparam int BIT = RW - 1 - g;
		logic [SW-1:0] trial;
		logic          fit;

		assign trial = ({{(SW-RW){1'b0}}, sr_root[g]} << (BIT + 1)) + (SW'(1) << (2 * BIT));
		assign fit   = sr_rem[g] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sr_v[g+1] <= 1'b0;
			else if (en) sr_v[g+1] <= sr_v[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sr_rem[g+1]  <= fit ? sr_rem[g] - trial : sr_rem[g];
				sr_root[g+1] <= fit ? (sr_root[g] | (RW'(1) << BIT)) : sr_root[g];
				sr_ctx[g+1]  <= sr_ctx[g];
			end
		end
	end

	// divide pipeline input, a zero root divides as one
	always_comb begin
		dv_v[0]   = sr_v[RW];
		dv_m[0]   = (sr_root[RW] == '0) ? 32'd1 : sr_root[RW];
		dv_ctx[0] = sr_ctx[RW];
		for (int l = 0; l < 3; l++) begin
			dv_rem[0][l] = {2'b00, sr_ctx[RW].bval[l]};
			dv_q[0][l]   = '0;
		end
	end

	// restoring division of b * 2^frac by the root, one quotient bit per stage
	for (genvar s = 0; s < QW; s++) begin : g_div
		localparam int J = FRAC_BITS - s;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[s+1] <= 1'b0;
			else if (en) dv_v[s+1] <= dv_v[s];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_m[s+1]   <= dv_m[s];
				dv_ctx[s+1] <= dv_ctx[s];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [32:0] cand;
			logic        ge;

			if (s == 0) begin : g_first
				assign cand = dv_rem[s][l];
			end else begin : g_next
				assign cand = {dv_rem[s][l][31:0], 1'b0};
			end
			assign ge = cand >= {1'b0, dv_m[s]};

			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem[s+1][l] <= ge ? cand - {1'b0, dv_m[s]} : cand;
					dv_q[s+1][l]   <= dv_q[s][l] | (QW'(ge) << J);
				end
			end
		end
	end

	// tail valid chain, the last stage is the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_v_s1   <= 1'b0;
			tl_v_s2   <= 1'b0;
			tl_v_s3   <= 1'b0;
			tl_v_s4   <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			tl_v_s1   <= dv_v[QW];
			tl_v_s2   <= tl_v_s1;
			tl_v_s3   <= tl_v_s2;
			tl_v_s4   <= tl_v_s3;
			out_valid <= tl_v_s4;
		end
	end

	// dot product sum and final reflection with saturation
	always_comb begin
		dsum = {{2{tl_prod_s2[0][63]}}, tl_prod_s2[0]} +
			{{2{tl_prod_s2[1][63]}}, tl_prod_s2[1]} +
			{{2{tl_prod_s2[2][63]}}, tl_prod_s2[2]};
		dsum_sh = dsum >>> FRAC_BITS;
		for (int i = 0; i < 3; i++) begin
			scl_sh[i] = tl_scl_s4[i] >>> (FRAC_BITS - 1);
			rdiff[i]  = {{4{tl_vec_s4[i][31]}}, tl_vec_s4[i]} - scl_sh[i][35:0];
			if (!rdiff[i][35] && (|rdiff[i][34:31])) begin
				rsat[i] = 32'h7FFF_FFFF;
			end else if (rdiff[i][35] && !(&rdiff[i][34:31])) begin
				rsat[i] = 32'h8000_0000;
			end else begin
				rsat[i] = rdiff[i][31:0];
			end
		end
	end

	// tail datapath
	always_ff @(posedge clk) begin
		if (en) begin
			// unit normal or clamped raw normal
			for (int i = 0; i < 3; i++) begin
				if (dv_ctx[QW].norm) begin
					tl_u_s1[i] <= dv_ctx[QW].neg[i] ? -(32'(dv_q[QW][i])) : 32'(dv_q[QW][i]);
				end else begin
					tl_u_s1[i] <= dv_ctx[QW].uraw[i];
				end
			end
			tl_vec_s1  <= dv_ctx[QW].vec;
			tl_norm_s1 <= dv_ctx[QW].norm;

			// normal times vector
			for (int i = 0; i < 3; i++) begin
				tl_prod_s2[i] <= tl_u_s1[i] * $signed(tl_vec_s1[i]);
			end
			tl_u_s2    <= tl_u_s1;
			tl_vec_s2  <= tl_vec_s1;
			tl_norm_s2 <= tl_norm_s1;

			// dot product
			tl_dot_s3  <= dsum_sh[DW-1:0];
			tl_u_s3    <= tl_u_s2;
			tl_vec_s3  <= tl_vec_s2;
			tl_norm_s3 <= tl_norm_s2;

			// normal scaled by the dot product
			for (int i = 0; i < 3; i++) begin
				tl_scl_s4[i] <= tl_u_s3[i] * tl_dot_s3;
			end
			tl_vec_s4  <= tl_vec_s3;
			tl_norm_s4 <= tl_norm_s3;

			// result register
			out_data.refl_x     <= rsat[0];
			out_data.refl_y     <= rsat[1];
			out_data.refl_z     <= rsat[2];
			out_data.normal_raw <= !tl_norm_s4;
		end
	end

endmodule

[sim/tb_householder_plane_reflect.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_householder_plane_reflect
// self-checking bench for the plane reflection block: random and directed
// geometry transactions, a bit-exact predictor, random idling on both sides
// and a sweep of the cross magnitude threshold
// ----------------------------------------------------------------------------
module tb_householder_plane_reflect;
	import hpr_pkg::*;

	localparam int FRAC       = FRAC_BITS_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE     = 120;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;

	out_item_t   pending_refl[$];
	logic [31:0] threshold;
	int          mismatches;
	int          idle_cycles;
	bit          calm;

	householder_plane_reflect u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// integer square root, floor
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// floor((a*b - c*d) / 2^FRAC), exact
	function automatic logic signed [65:0] cross_floor(logic signed [31:0] a,
			logic signed [31:0] b, logic signed [31:0] c, logic signed [31:0] d);
		logic signed [65:0] ea, eb, ec, ed, diff;
		ea   = a;
		eb   = b;
		ec   = c;
		ed   = d;
		diff = ea * eb - ec * ed;
		return diff >>> FRAC;
	endfunction

	// expected reflection of one transaction under threshold thr
	function automatic out_item_t predict_reflection(in_item_t it, logic [31:0] thr);
		logic signed [31:0]  lk[3], ob[3], vc[3];
		logic signed [65:0]  cr[3], un[3], ev, dsum, dot;
		logic [65:0]         mag[3], sq, mx;
		logic [63:0]         t2, bsum, bm[3], root, q;
		logic signed [131:0] prod;
		logic signed [65:0]  r;
		logic                big, norm;
		int                  k;
		out_item_t           res;
		lk[0] = it.look_x; lk[1] = it.look_y; lk[2] = it.look_z;
		ob[0] = it.obs_x;  ob[1] = it.obs_y;  ob[2] = it.obs_z;
		vc[0] = it.vec_x;  vc[1] = it.vec_y;  vc[2] = it.vec_z;
		cr[0] = cross_floor(lk[1], ob[2], lk[2], ob[1]);
		cr[1] = cross_floor(lk[2], ob[0], lk[0], ob[2]);
		cr[2] = cross_floor(lk[0], ob[1], lk[1], ob[0]);
		big = 1'b0;
		sq  = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
			if (mag[i] > 66'hFFFF_FFFF)
				big = 1'b1;
			else
				sq = sq + mag[i] * mag[i];
		end
		t2   = {32'd0, thr} * {32'd0, thr};
		norm = big || (sq > {2'b00, t2});
		if (norm) begin
			// scale down until the largest component fits 31 bits
			mx = mag[0];
			if (mag[1] > mx) mx = mag[1];
			if (mag[2] > mx) mx = mag[2];
			k = 0;
			while ((mx >> k) >= 66'h8000_0000)
				k++;
			bsum = '0;
			for (int i = 0; i < 3; i++) begin
				bm[i] = 64'(mag[i] >> k);
				bsum  = bsum + bm[i] * bm[i];
			end
			root = int_sqrt(bsum);
			if (root == 0) root = 1;
			for (int i = 0; i < 3; i++) begin
				q     = (bm[i] << FRAC) / root;
				un[i] = cr[i] < 0 ? -$signed({2'b00, q}) : $signed({2'b00, q});
			end
		end else begin
			// raw normal clamped to plus or minus one
			for (int i = 0; i < 3; i++) begin
				if (cr[i] > (66'sd1 <<< FRAC))
					un[i] = 66'sd1 <<< FRAC;
				else if (cr[i] < -(66'sd1 <<< FRAC))
					un[i] = -(66'sd1 <<< FRAC);
				else
					un[i] = cr[i];
			end
		end
		dsum = '0;
		for (int i = 0; i < 3; i++) begin
			ev   = vc[i];
			dsum = dsum + un[i] * ev;
		end
		dot = dsum >>> FRAC;
		for (int i = 0; i < 3; i++) begin
			prod = un[i] * dot;
			ev   = vc[i];
			r    = ev - 66'(prod >>> (FRAC - 1));
			if (r > 66'sd2147483647)
				r = 66'sd2147483647;
			if (r < -66'sd2147483648)
				r = -66'sd2147483648;
			case (i)
				0: res.refl_x = r[31:0];
				1: res.refl_y = r[31:0];
				default: res.refl_z = r[31:0];
			endcase
		end
		res.normal_raw = ~norm;
		return res;
	endfunction

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int p;
		if (calm) return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// random value with a random magnitude
	function automatic logic [31:0] scaled_rand();
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(0, 31);
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int       mode;
		mode = $urandom_range(0, 9);
		it   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		if (mode >= 3) begin
			// look within about one, observer and vector of mixed scale
			it.look_x = $signed($urandom) >>> 1;
			it.look_y = $signed($urandom) >>> 1;
			it.look_z = $signed($urandom) >>> 1;
			it.obs_x  = scaled_rand();
			it.obs_y  = scaled_rand();
			it.obs_z  = scaled_rand();
			it.vec_x  = scaled_rand();
			it.vec_y  = scaled_rand();
			it.vec_z  = scaled_rand();
		end
		if (mode == 8) begin
			// observer from look shifted per component; equal shifts make it parallel
			it.obs_x = it.look_x >>> $urandom_range(0, 8);
			it.obs_y = it.look_y >>> $urandom_range(0, 8);
			it.obs_z = it.look_z >>> $urandom_range(0, 8);
		end
		if (mode == 9) begin
			// tiny observer keeps the cross product small
			it.obs_x = $signed($urandom) >>> $urandom_range(20, 31);
			it.obs_y = $signed($urandom) >>> $urandom_range(20, 31);
			it.obs_z = $signed($urandom) >>> $urandom_range(20, 31);
		end
		return it;
	endfunction

	// send one transaction and log its expected reflection
	task automatic send_item(in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_refl = {pending_refl, predict_reflection(it, threshold)};
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			in_data  <= {$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_refl.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_threshold(logic [31:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_wdata <= $urandom;
		threshold = value;
	endtask

	task automatic send_geometry(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
			logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
		send_item({lx, ly, lz, ox, oy, oz, vx, vy, vz});
	endtask

	// corners: zero cross, extremes of every field, unit axes
	task automatic test_directed();
		localparam logic [31:0] ONE  = 32'h4000_0000;
		localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
		localparam logic [31:0] MINV = 32'h8000_0000;
		calm = 1'b1;
		send_geometry(0, 0, 0, MAXV, MINV, 5, MAXV, MINV, ONE);
		send_geometry(ONE, 0, 0, ONE, 0, 0, 123, -456, 789);
		send_geometry(ONE, 0, 0, 0, ONE, 0, ONE, ONE, ONE);
		send_geometry(0, ONE, 0, 0, 0, ONE, MAXV, MAXV, MAXV);
		send_geometry(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV, MINV);
		send_geometry(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV);
		send_geometry(MINV, 0, 0, 0, MINV, 0, MINV, MINV, MINV);
		send_geometry(MAXV, MAXV, 0, MINV, MAXV, 0, MAXV, MAXV, MINV);
		send_geometry(ONE, 0, 0, 0, 1, 0, MAXV, MINV, MAXV);
		send_geometry(ONE, 0, 0, 0, 2, 0, 0, 0, MAXV);
		send_geometry(ONE, ONE, 0, 0, 0, 1, MAXV, MINV, 0);
		send_geometry(32'hFFFF_FFFF, 1, 0, 0, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0);
		send_geometry(0, 0, 0, 0, 0, 0, 0, 0, 0);
		calm = 1'b0;
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
			send_item(random_item());
		end
		calm = 1'b0;
	endtask

	// thresholds: extremes and a few settings in between
	task automatic test_threshold_sweep();
		write_threshold(32'hFFFF_FFFF);
		test_directed();
		test_random(300);
		write_threshold(32'd0);
		test_directed();
		test_random(300);
		write_threshold($urandom_range(1, 32'h000F_FFFF));
		test_random(300);
		write_threshold($urandom);
		test_random(250);
		write_threshold(MIN_CROSS_RESET);
		test_random(100);
	endtask

	// result stall pattern: bursts of random length
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (calm) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			out_stall  <= 1'b0;
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_refl.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: x=%h y=%h z=%h raw=%b",
						out_data.refl_x, out_data.refl_y, out_data.refl_z,
						out_data.normal_raw);
			end else begin
				want = pending_refl.pop_front();
				if (out_data.refl_x !== want.refl_x || out_data.refl_y !== want.refl_y ||
						out_data.refl_z !== want.refl_z ||
						out_data.normal_raw !== want.normal_raw) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%h y=%h z=%h raw=%b got x=%h y=%h z=%h raw=%b",
							want.refl_x, want.refl_y, want.refl_z, want.normal_raw,
							out_data.refl_x, out_data.refl_y, out_data.refl_z,
							out_data.normal_raw);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// test sequence
	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		threshold   = MIN_CROSS_RESET;
		mismatches  = 0;
		idle_cycles = 0;
		calm        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		test_threshold_sweep();
		drain();
		if (mismatches == 0 && pending_refl.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
